FILE: sv/c1ks_pkg.sv
// ----------------------------------------------------------------------------
// c1ks_pkg
// Shared types, constants and filter/feedback functions of the keystream block
// ----------------------------------------------------------------------------
package c1ks_pkg;

  localparam int STATE_W    = 48;
  localparam int UID_W      = 32;
  localparam int BYTE_W     = 8;
  localparam int MIX_CNT_W  = 3;
  localparam int NUM_TAPS   = 18;

  localparam logic [MIX_CNT_W-1:0] MIX_BYTES = 3'd4;
  localparam logic [MIX_CNT_W-1:0] MIX_ONE   = 3'd1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // feedback taps as cipher positions, position p is state bit 47 - p
  localparam int TAP_POS [NUM_TAPS] = '{
    0, 5, 9, 10, 12, 14, 15, 17, 19, 24, 25, 27, 29, 35, 39, 41, 42, 43
  };

  typedef struct packed {
    logic                opcode;
    logic [STATE_W-1:0]  key;
    logic [UID_W-1:0]    tag_nonce;
    logic [BYTE_W-1:0]   data_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] keystream_byte;
    logic [BYTE_W-1:0] cipher_byte;
  } out_item_t;

  function automatic logic flt_a(input logic a, input logic b, input logic c,
                                 input logic d);
    return (a | b) ^ (a & d) ^ (c & ((a ^ b) | d));
  endfunction

  function automatic logic flt_b(input logic a, input logic b, input logic c,
                                 input logic d);
    return ((a & b) | c) ^ ((a ^ b) & (c | d));
  endfunction

  function automatic logic flt_c(input logic a, input logic b, input logic c,
                                 input logic d, input logic e);
    return (a | ((b | e) & (d ^ e))) ^ ((a ^ (b & d)) & ((c ^ d) | (b & e)));
  endfunction

  // cipher position p maps to state bit 47 - p
  function automatic logic filter_bit(input logic [STATE_W-1:0] s);
    logic g0, g1, g2, g3, g4;
    g0 = flt_a(s[38], s[36], s[34], s[32]);
    g1 = flt_b(s[30], s[28], s[26], s[24]);
    g2 = flt_b(s[22], s[20], s[18], s[16]);
    g3 = flt_a(s[14], s[12], s[10], s[8]);
    g4 = flt_b(s[6],  s[4],  s[2],  s[0]);
    return flt_c(g0, g1, g2, g3, g4);
  endfunction

  function automatic logic feedback_bit(input logic [STATE_W-1:0] s);
    logic r;
    r = 1'b0;
    for (int i = 0; i < NUM_TAPS; i++) begin
      r = r ^ s[STATE_W-1-TAP_POS[i]];
    end
    return r;
  endfunction

endpackage

FILE: sv/c1ks_byte_round.sv
// ----------------------------------------------------------------------------
// c1ks_byte_round
// Eight unrolled lfsr clocks: one keystream byte and the advanced state
// ----------------------------------------------------------------------------
module c1ks_byte_round (
  input  logic [c1ks_pkg::STATE_W-1:0] state_in,
  input  logic [c1ks_pkg::BYTE_W-1:0]  mix_byte,
  output logic [c1ks_pkg::STATE_W-1:0] state_out,
  output logic [c1ks_pkg::BYTE_W-1:0]  ks_byte
);

  logic [c1ks_pkg::STATE_W-1:0] s [c1ks_pkg::BYTE_W+1];

  assign s[0] = state_in;

  for (genvar i = 0; i < c1ks_pkg::BYTE_W; i++) begin : g_clk
    logic nb;
    // filter taken before the shift, msb first
    assign ks_byte[c1ks_pkg::BYTE_W-1-i] = c1ks_pkg::filter_bit(s[i]);
    assign nb = c1ks_pkg::feedback_bit(s[i]) ^ mix_byte[c1ks_pkg::BYTE_W-1-i];
    assign s[i+1] = {s[i][c1ks_pkg::STATE_W-2:0], nb};
  end

  assign state_out = s[c1ks_pkg::BYTE_W];

endmodule

FILE: sv/crypto1_keystream_generator.sv
// ----------------------------------------------------------------------------
// crypto1_keystream_generator
// Crypto1 keystream: 48-bit lfsr, uid/nonce mixing, one byte per transfer
// ----------------------------------------------------------------------------
// channel  direction  payload      transfer
// in       sink       in_item_t    in_valid & in_ready
// out      source     out_item_t   out_valid & out_ready
// cfg      sink       card_uid     cfg_valid & cfg_ready
//
// one item per cycle while the output is not stalled; the result is registered at the input transfer
// the eight lfsr clocks of a byte are one combinational pass into the state
// and result registers; the state loop sets the rate
// reset clears state, nonce, mix count, card uid and the output valid
// in_ready drops only while a result is held and out_ready is low
// cfg_ready is always high
// ----------------------------------------------------------------------------
module crypto1_keystream_generator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  c1ks_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output c1ks_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [c1ks_pkg::UID_W-1:0] cfg_data
);

  logic [c1ks_pkg::UID_W-1:0]     card_uid;
  logic [c1ks_pkg::STATE_W-1:0]   cipher_state;
  logic [c1ks_pkg::STATE_W-1:0]   cipher_state_next;
  logic [c1ks_pkg::UID_W-1:0]     saved_nonce;
  logic [c1ks_pkg::MIX_CNT_W-1:0] mix_count;
  logic [c1ks_pkg::MIX_CNT_W-1:0] mix_count_next;
  logic [c1ks_pkg::UID_W-1:0]     mix_word;
  logic [c1ks_pkg::BYTE_W-1:0]    mix_byte;
  logic [c1ks_pkg::BYTE_W-1:0]    ks_byte;
  logic                           mixing;
  logic                           in_xfer;
  c1ks_pkg::out_item_t            result;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_xfer   = in_valid && in_ready;

  assign mixing   = mix_count < c1ks_pkg::MIX_BYTES;
  assign mix_word = card_uid ^ saved_nonce;
  assign mix_byte = mixing ? mix_word[c1ks_pkg::BYTE_W*mix_count[1:0] +: c1ks_pkg::BYTE_W]
                           : '0;

  c1ks_byte_round u_round (
    .state_in  (cipher_state),
    .mix_byte  (mix_byte),
    .state_out (cipher_state_next),
    .ks_byte   (ks_byte)
  );

  assign mix_count_next = mixing ? mix_count + c1ks_pkg::MIX_ONE : mix_count;

  always_comb begin
    unique case (in_data.opcode)
      c1ks_pkg::OP_LOAD: begin
        result.keystream_byte = '0;
        result.cipher_byte    = '0;
      end
      c1ks_pkg::OP_STEP: begin
        result.keystream_byte = ks_byte;
        result.cipher_byte    = ks_byte ^ in_data.data_byte;
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      card_uid <= '0;
    end else if (cfg_valid && cfg_ready) begin
      card_uid <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_state <= '0;
      saved_nonce  <= '0;
      mix_count    <= '0;
    end else if (in_xfer) begin
      if (in_data.opcode == c1ks_pkg::OP_LOAD) begin
        cipher_state <= in_data.key;
        saved_nonce  <= in_data.tag_nonce;
        mix_count    <= '0;
      end else begin
        cipher_state <= cipher_state_next;
        mix_count    <= mix_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data <= result;
    end
  end

  // mix counter saturates at the mix byte count
  a_mix_bound: assert property (@(posedge clk) disable iff (rst)
    mix_count <= c1ks_pkg::MIX_BYTES)
    else $error("mix count past limit");

  // a load transfer restarts mixing and yields a zero result
  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    in_xfer && in_data.opcode == c1ks_pkg::OP_LOAD |=>
      mix_count == '0 && out_valid && out_data == '0)
    else $error("load transfer did not clear");

  // a step transfer consumes one mix byte while mixing
  a_mix_advance: assert property (@(posedge clk) disable iff (rst)
    in_xfer && in_data.opcode == c1ks_pkg::OP_STEP && mixing |=>
      mix_count == $past(mix_count) + c1ks_pkg::MIX_ONE)
    else $error("mix count did not advance");

  // on a step transfer the cipher byte is keystream xor data
  a_cipher_xor: assert property (@(posedge clk) disable iff (rst)
    in_xfer && in_data.opcode == c1ks_pkg::OP_STEP |=>
      out_data.cipher_byte == (out_data.keystream_byte ^ $past(in_data.data_byte)))
    else $error("cipher byte mismatch");

  // the state holds without an input transfer
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !in_xfer |=> $stable(cipher_state) && $stable(mix_count))
    else $error("state changed without transfer");

endmodule

FILE: tb/tb_crypto1_keystream_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crypto1_keystream_generator
// Drives key loads and keystream steps through the input channel and checks
// every returned byte against a bit-level lfsr predictor kept in step with
// the accepted transfers. Card uid writes go in between traffic phases.
// Sender and receiver idle at random, and one long receiver hold-off backs
// the block up.
// ----------------------------------------------------------------------------
module tb_crypto1_keystream_generator;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  class keystream_predictor;
    logic [c1ks_pkg::STATE_W-1:0]   lfsr;
    logic [c1ks_pkg::UID_W-1:0]     nonce;
    logic [c1ks_pkg::UID_W-1:0]     card_uid;
    logic [c1ks_pkg::MIX_CNT_W-1:0] mixed;
    c1ks_pkg::out_item_t            expected_bytes[$];
    int                             errors;

    function new();
      lfsr     = '0;
      nonce    = '0;
      card_uid = '0;
      mixed    = '0;
      errors   = 0;
    endfunction

    function logic bit_at(logic [c1ks_pkg::STATE_W-1:0] s, int p);
      return s[c1ks_pkg::STATE_W-1-p];
    endfunction

    function logic nl_a(logic a, logic b, logic c, logic d);
      return ((a | b) ^ (a & d)) ^ (c & ((a ^ b) | d));
    endfunction

    function logic nl_b(logic a, logic b, logic c, logic d);
      return ((a & b) | c) ^ ((a ^ b) & (c | d));
    endfunction

    function logic nl_c(logic a, logic b, logic c, logic d, logic e);
      return (a | ((b | e) & (d ^ e))) ^ ((a ^ (b & d)) & ((c ^ d) | (b & e)));
    endfunction

    function logic quad(logic [c1ks_pkg::STATE_W-1:0] s, int first, bit use_a);
      logic w, x, y, z;
      w = bit_at(s, first);
      x = bit_at(s, first + 2);
      y = bit_at(s, first + 4);
      z = bit_at(s, first + 6);
      return use_a ? nl_a(w, x, y, z) : nl_b(w, x, y, z);
    endfunction

    function logic keystream_bit(logic [c1ks_pkg::STATE_W-1:0] s);
      return nl_c(quad(s, 9, 1'b1), quad(s, 17, 1'b0), quad(s, 25, 1'b0),
                  quad(s, 33, 1'b1), quad(s, 41, 1'b0));
    endfunction

    function logic lfsr_feedback(logic [c1ks_pkg::STATE_W-1:0] s);
      return bit_at(s, 0) ^ bit_at(s, 5) ^ bit_at(s, 9) ^ bit_at(s, 10) ^
             bit_at(s, 12) ^ bit_at(s, 14) ^ bit_at(s, 15) ^ bit_at(s, 17) ^
             bit_at(s, 19) ^ bit_at(s, 24) ^ bit_at(s, 25) ^ bit_at(s, 27) ^
             bit_at(s, 29) ^ bit_at(s, 35) ^ bit_at(s, 39) ^ bit_at(s, 41) ^
             bit_at(s, 42) ^ bit_at(s, 43);
    endfunction

    function void note_transfer(c1ks_pkg::in_item_t it);
      c1ks_pkg::out_item_t          r;
      logic [c1ks_pkg::UID_W-1:0]   mix_word;
      logic [c1ks_pkg::BYTE_W-1:0]  mix;
      logic [c1ks_pkg::BYTE_W-1:0]  ks;
      logic                         nb;
      r   = '0;
      mix = '0;
      ks  = '0;
      if (it.opcode == c1ks_pkg::OP_LOAD) begin
        lfsr  = it.key;
        nonce = it.tag_nonce;
        mixed = '0;
      end else begin
        // uid ^ nonce bytes feed the lfsr, low byte first, until four are used
        if (mixed < c1ks_pkg::MIX_BYTES) begin
          mix_word = (card_uid ^ nonce) >> (8 * mixed);
          mix      = mix_word[c1ks_pkg::BYTE_W-1:0];
          mixed    = mixed + c1ks_pkg::MIX_ONE;
        end
        for (int i = 0; i < c1ks_pkg::BYTE_W; i++) begin
          ks   = {ks[c1ks_pkg::BYTE_W-2:0], keystream_bit(lfsr)};
          nb   = lfsr_feedback(lfsr) ^ mix[c1ks_pkg::BYTE_W-1-i];
          lfsr = {lfsr[c1ks_pkg::STATE_W-2:0], nb};
        end
        r.keystream_byte = ks;
        r.cipher_byte    = ks ^ it.data_byte;
      end
      expected_bytes.push_back(r);
    endfunction

    function void check_byte(c1ks_pkg::out_item_t got);
      c1ks_pkg::out_item_t want;
      if (expected_bytes.size() == 0) begin
        $display("%0t: result with none expected, actual ks %02h cipher %02h",
                 $time, got.keystream_byte, got.cipher_byte);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.keystream_byte !== want.keystream_byte) begin
        $display("%0t: keystream_byte mismatch, expected %02h, actual %02h",
                 $time, want.keystream_byte, got.keystream_byte);
        errors++;
      end
      if (got.cipher_byte !== want.cipher_byte) begin
        $display("%0t: cipher_byte mismatch, expected %02h, actual %02h",
                 $time, want.cipher_byte, got.cipher_byte);
        errors++;
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  c1ks_pkg::in_item_t           in_data;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  c1ks_pkg::out_item_t          out_data;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [c1ks_pkg::UID_W-1:0]   cfg_data;

  keystream_predictor ks_model = new();
  int                 send_idle_pct = 19;
  int                 recv_idle_pct = 82;
  int                 hold_left = 0;
  int                 quiet_cycles = 0;

  crypto1_keystream_generator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // transfer monitor
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (in_valid && in_ready) begin
        ks_model.note_transfer(in_data);
      end
      if (out_valid && out_ready) begin
        ks_model.check_byte(out_data);
      end
      if (cfg_valid && cfg_ready) begin
        ks_model.card_uid = cfg_data;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // receiver with random stalls and an optional long hold-off
  initial begin
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic c1ks_pkg::in_item_t make_item(logic op,
                                                   logic [c1ks_pkg::STATE_W-1:0] key,
                                                   logic [c1ks_pkg::UID_W-1:0] nonce,
                                                   logic [c1ks_pkg::BYTE_W-1:0] data);
    c1ks_pkg::in_item_t it;
    it.opcode    = op;
    it.key       = key;
    it.tag_nonce = nonce;
    it.data_byte = data;
    return it;
  endfunction

  function automatic c1ks_pkg::in_item_t rand_item(logic op);
    c1ks_pkg::in_item_t it;
    int                 pick;
    it   = make_item(op, {16'($urandom), 32'($urandom)}, 32'($urandom),
                     8'($urandom));
    pick = $urandom_range(19);
    if (pick == 0) begin
      it.key = '0;
    end else if (pick == 1) begin
      it.key = '1;
    end else if (pick == 2) begin
      it.tag_nonce = '0;
    end else if (pick == 3) begin
      it.tag_nonce = '1;
    end
    return it;
  endfunction

  task automatic send_item(input c1ks_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    repeat (2) @(posedge clk);
    while (ks_model.expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_uid(input logic [c1ks_pkg::UID_W-1:0] uid);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= uid;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_traffic(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 85) begin
        send_item(rand_item(c1ks_pkg::OP_LOAD));
        sent++;
        repeat ($urandom_range(1, 12)) begin
          send_item(rand_item(c1ks_pkg::OP_STEP));
          sent++;
        end
      end else begin
        send_item(rand_item(logic'($urandom_range(1))));
        sent++;
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // step from the reset state, then all-zero key with uid still zero
    send_item(make_item(c1ks_pkg::OP_STEP, '1, '1, 8'hff));
    send_item(make_item(c1ks_pkg::OP_LOAD, '0, '0, 8'hff));
    send_item(make_item(c1ks_pkg::OP_STEP, '0, '0, 8'h00));
    in_valid <= 1'b0;

    // all-ones uid, all four mix bytes then plain stepping
    write_uid('1);
    send_item(make_item(c1ks_pkg::OP_LOAD, '1, '0, 8'h00));
    send_item(make_item(c1ks_pkg::OP_STEP, 48'h5555_aaaa_5555, 32'h1234_5678, 8'h00));
    send_item(make_item(c1ks_pkg::OP_STEP, '1, '1, 8'hff));
    send_item(make_item(c1ks_pkg::OP_STEP, '0, '0, 8'h5a));
    send_item(make_item(c1ks_pkg::OP_STEP, '1, '0, 8'ha5));
    send_item(make_item(c1ks_pkg::OP_STEP, '0, '1, 8'hff));
    send_item(make_item(c1ks_pkg::OP_LOAD, 48'h1234_5678_9abc, '1, 8'hff));
    send_item(make_item(c1ks_pkg::OP_STEP, '0, '0, 8'h01));
    send_item(make_item(c1ks_pkg::OP_STEP, '0, '0, 8'h80));
    // reload in the middle of mixing restarts the byte count
    send_item(make_item(c1ks_pkg::OP_LOAD, 48'h8000_0000_0001, 32'h8000_0001, 8'h00));
    repeat (5) send_item(make_item(c1ks_pkg::OP_STEP, '0, '0, 8'($urandom)));
    in_valid <= 1'b0;

    write_uid(32'($urandom));
    run_traffic(450);

    send_idle_pct = 82;
    recv_idle_pct = 19;
    write_uid('0);
    run_traffic(450);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_uid(32'($urandom));
    hold_left = HOLD_CYCLES;
    run_traffic(500);

    wait_drained();
    if (ks_model.errors == 0 && ks_model.expected_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
